>>> hdl/ecd_pkg.sv
// Shared types, constants and small lookup tables for the epoch-to-date converter.
// No dependencies; used by epoch_seconds_to_calendar_date_core.
`default_nettype none

package ecd_pkg;

	// Field widths of the ports
	localparam int EPOCH_W = 36;
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	// Register stages from input to output
	localparam int STAGES = 16;

	// Seconds per day = 2^7 * 675: the low seven bits bypass the divider
	localparam int SEC_LO_W = 7;
	localparam int DAY_DIV  = 675;
	localparam int HOUR_DIV = 3600;
	localparam int MIN_DIV  = 60;

	// Julian-day method constants
	localparam logic [21:0] T1_BIAS   = 22'd102032;
	localparam int          T1_DIV    = 146097;
	localparam logic [5:0]  T1_OFS    = 6'd15;
	localparam logic [21:0] T2_BIAS   = 22'd2442113;
	localparam logic [25:0] YR_MUL    = 26'd20;
	localparam logic [25:0] YR_BIAS   = 26'd2442;
	localparam int          YR_DIV    = 7305;
	localparam logic [21:0] DAYS_YEAR = 22'd365;
	localparam logic [18:0] MO_MUL    = 19'd1000;
	localparam int          MO_DIV    = 30601;
	localparam logic [8:0]  DAYS_MO   = 9'd30;
	localparam logic [4:0]  MO_SPLIT  = 5'd13;
	localparam logic [13:0] YR_OFS_LO = 14'd4716;
	localparam logic [13:0] YR_OFS_HI = 14'd4715;

	// Zeller's congruence: century split and bias (7*20 less the day offset of one)
	localparam int          CENT_DIV  = 100;
	localparam logic [9:0]  ZEL_BIAS  = 10'd139;
	localparam int          WEEK_DIV  = 7;
	localparam logic [3:0]  MARCH     = 4'd3;
	localparam logic [3:0]  MO_YEAR   = 4'd12;

	// Per-beat payload carried down the pipeline; each stage fills what it computes
	typedef struct packed {
		logic [SEC_LO_W-1:0] ts_lo;
		logic [19:0]         days;
		logic [HOUR_W-1:0]   hour;
		logic [MIN_W-1:0]    minute;
		logic [SEC_W-1:0]    second;
		logic [21:0]         t2;
		logic [13:0]         yr;
		logic [8:0]          t3;
		logic [12:0]         year;
		logic [MONTH_W-1:0]  month;
		logic [DOM_W-1:0]    dom;
		logic [3:0]          mz;
		logic [8:0]          sum;
	} lane_t;

	// floor(m * 601 / 1000)
	function automatic logic [4:0] month_frac(input logic [4:0] m);
		logic [4:0] r;
		case (m)
			5'd0, 5'd1:   r = 5'd0;
			5'd2, 5'd3:   r = 5'd1;
			5'd4:         r = 5'd2;
			5'd5, 5'd6:   r = 5'd3;
			5'd7, 5'd8:   r = 5'd4;
			5'd9:         r = 5'd5;
			5'd10, 5'd11: r = 5'd6;
			5'd12, 5'd13: r = 5'd7;
			5'd14:        r = 5'd8;
			5'd15, 5'd16: r = 5'd9;
			5'd17, 5'd18: r = 5'd10;
			5'd19:        r = 5'd11;
			5'd20, 5'd21: r = 5'd12;
			5'd22, 5'd23: r = 5'd13;
			5'd24:        r = 5'd14;
			5'd25, 5'd26: r = 5'd15;
			5'd27, 5'd28: r = 5'd16;
			5'd29:        r = 5'd17;
			default:      r = 5'd18;
		endcase
		return r;
	endfunction

	// floor(13 * (m + 1) / 5)
	function automatic logic [5:0] zeller_month(input logic [3:0] m);
		logic [5:0] r;
		case (m)
			4'd0:    r = 6'd2;
			4'd1:    r = 6'd5;
			4'd2:    r = 6'd7;
			4'd3:    r = 6'd10;
			4'd4:    r = 6'd13;
			4'd5:    r = 6'd15;
			4'd6:    r = 6'd18;
			4'd7:    r = 6'd20;
			4'd8:    r = 6'd23;
			4'd9:    r = 6'd26;
			4'd10:   r = 6'd28;
			4'd11:   r = 6'd31;
			4'd12:   r = 6'd33;
			4'd13:   r = 6'd36;
			4'd14:   r = 6'd39;
			default: r = 6'd41;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ecd_const_div.sv
// Two-stage divider by a constant: reciprocal estimate, then one correction step.
// Standalone; instantiated by epoch_seconds_to_calendar_date_core.
`default_nettype none

module ecd_const_div #(
	parameter int NUM_W   = 8,
	parameter int QUO_W   = 8,
	parameter int REM_W   = 8,
	parameter int DIVISOR = 3
) (
	input  logic             clk,
	input  logic             en_a,
	input  logic             en_b,
	input  logic [NUM_W-1:0] num,
	output logic [QUO_W-1:0] quo,
	output logic [REM_W-1:0] rem
);

	// floor(2^NUM_W / DIVISOR): estimate is exact or one short
	localparam longint unsigned RecipL = (64'd1 << NUM_W) / DIVISOR;
	localparam logic [NUM_W-1:0] Recip = NUM_W'(RecipL);
	localparam logic [NUM_W-1:0] DivN  = NUM_W'(DIVISOR);

	logic [2*NUM_W-1:0] prod;
	logic [NUM_W-1:0]   num_s1;
	logic [QUO_W-1:0]   est_s1;
	logic [NUM_W-1:0]   back;
	logic [NUM_W-1:0]   resid;

	assign prod = {{NUM_W{1'b0}}, num} * {{NUM_W{1'b0}}, Recip};

	always_ff @(posedge clk) begin
		if (en_a) begin
			num_s1 <= num;
			est_s1 <= QUO_W'(prod[2*NUM_W-1:NUM_W]);
		end
	end

	assign back  = NUM_W'(est_s1) * DivN;
	assign resid = num_s1 - back;

	always_ff @(posedge clk) begin
		if (en_b) begin
			if (resid >= DivN) begin
				quo <= est_s1 + QUO_W'(1);
				rem <= REM_W'(resid - DivN);
			end else begin
				quo <= est_s1;
				rem <= REM_W'(resid);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/epoch_seconds_to_calendar_date_core.sv
// Top level of the epoch-seconds to calendar date and time converter.
// Depends on ecd_pkg and ecd_const_div.
`default_nettype none

// Converts a count of seconds since 1970-01-01 00:00:00 into year, month,
// day of month, weekday (0 = Sunday), hour, minute and second. The block is a
// pipeline of 16 register stages: each timestamp beat produces exactly one date
// beat, and date_valid rises once the beat has reached the last stage. A new
// beat can be accepted every cycle while epoch_ready is high, that is unless
// backpressure from date_ready has filled every stage.
// Throughput is one beat per clock, set by the fully pipelined constant
// dividers (each a reciprocal multiply stage plus a correction stage). On
// backpressure only the stages that hold data stall; empty stages keep
// filling, so epoch_ready stays high until every stage holds a beat.
// epoch_ready depends combinationally on date_ready. The block holds no state
// beyond the pipeline; year carries the low 12 bits of the true year for
// inputs past the end of year 4095. No configuration, no clearing pass.
module epoch_seconds_to_calendar_date_core (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         epoch_valid,
	output logic                         epoch_ready,
	input  logic [ecd_pkg::EPOCH_W-1:0]  epoch_seconds,

	output logic                         date_valid,
	input  logic                         date_ready,
	output logic [ecd_pkg::YEAR_W-1:0]   year,
	output logic [ecd_pkg::MONTH_W-1:0]  month,
	output logic [ecd_pkg::DOM_W-1:0]    day_of_month,
	output logic [ecd_pkg::WDAY_W-1:0]   weekday,
	output logic [ecd_pkg::HOUR_W-1:0]   hour,
	output logic [ecd_pkg::MIN_W-1:0]    minute,
	output logic [ecd_pkg::SEC_W-1:0]    second
);

	localparam int NS = ecd_pkg::STAGES;
	localparam logic [NS-1:0] AllVld = {NS{1'b1}};
	localparam int DayNumW = ecd_pkg::EPOCH_W - ecd_pkg::SEC_LO_W;

	// Stage valid bits and per-stage load enables
	logic [NS-1:0] vld_s;
	logic [NS-1:0] vld_in;
	logic [NS-1:0] en;

	ecd_pkg::lane_t lane_s [NS];
	ecd_pkg::lane_t lane_d [NS];

	// Divider results, each aligned with the lane stage noted
	logic [19:0] day_q;  logic [9:0]  day_r;   // stage 1
	logic [4:0]  hr_q;   logic [11:0] hr_r;    // stage 3
	logic [4:0]  t1_q;   logic [17:0] t1_r;    // stage 3
	logic [5:0]  min_q;  logic [5:0]  min_r;   // stage 5
	logic [13:0] yr_q;   logic [12:0] yr_r;    // stage 6
	logic [4:0]  mo_q;   logic [14:0] mo_r;    // stage 9
	logic [5:0]  cent_q; logic [6:0]  yoc;     // stage 12
	logic [5:0]  wk_q;   logic [2:0]  wk_r;    // stage 15

	// Divider operands
	logic [16:0] sod;
	logic [21:0] t1_num;
	logic [5:0]  t1;
	logic [25:0] yr_num;
	logic [18:0] mo_num;
	logic [12:0] yz;

	// ------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or everything downstream
	// of it can move.
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			en[i] = date_ready || ((vld_s >> i) != (AllVld >> i));
		end
	end

	assign vld_in      = {vld_s[NS-2:0], epoch_valid};
	assign epoch_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (en & vld_in) | (~en & vld_s);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NS; i++) begin
			if (en[i]) begin
				lane_s[i] <= lane_d[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Dividers. Stage pairs: day 0/1, hour and t1 2/3, minute 4/5,
	// year 5/6, month 8/9, century 11/12, weekday 14/15.
	// ------------------------------------------------------------------
	ecd_const_div #(
		.NUM_W(DayNumW), .QUO_W(20), .REM_W(10), .DIVISOR(ecd_pkg::DAY_DIV)
	) u_day (
		.clk(clk), .en_a(en[0]), .en_b(en[1]),
		.num(epoch_seconds[ecd_pkg::EPOCH_W-1:ecd_pkg::SEC_LO_W]),
		.quo(day_q), .rem(day_r)
	);

	// Second of day: day remainder rejoined with the bypassed low bits
	assign sod    = {day_r, lane_s[1].ts_lo};
	assign t1_num = {day_q, 2'b00} + ecd_pkg::T1_BIAS;

	ecd_const_div #(
		.NUM_W(17), .QUO_W(5), .REM_W(12), .DIVISOR(ecd_pkg::HOUR_DIV)
	) u_hour (
		.clk(clk), .en_a(en[2]), .en_b(en[3]),
		.num(sod), .quo(hr_q), .rem(hr_r)
	);

	ecd_const_div #(
		.NUM_W(22), .QUO_W(5), .REM_W(18), .DIVISOR(ecd_pkg::T1_DIV)
	) u_t1 (
		.clk(clk), .en_a(en[2]), .en_b(en[3]),
		.num(t1_num), .quo(t1_q), .rem(t1_r)
	);

	ecd_const_div #(
		.NUM_W(12), .QUO_W(6), .REM_W(6), .DIVISOR(ecd_pkg::MIN_DIV)
	) u_min (
		.clk(clk), .en_a(en[4]), .en_b(en[5]),
		.num(hr_r), .quo(min_q), .rem(min_r)
	);

	// 20*t2 never drops below the bias: t2 starts above 2442113
	assign yr_num = 26'(lane_s[4].t2) * ecd_pkg::YR_MUL - ecd_pkg::YR_BIAS;

	ecd_const_div #(
		.NUM_W(26), .QUO_W(14), .REM_W(13), .DIVISOR(ecd_pkg::YR_DIV)
	) u_yr (
		.clk(clk), .en_a(en[5]), .en_b(en[6]),
		.num(yr_num), .quo(yr_q), .rem(yr_r)
	);

	assign mo_num = 19'(lane_s[7].t3) * ecd_pkg::MO_MUL;

	ecd_const_div #(
		.NUM_W(19), .QUO_W(5), .REM_W(15), .DIVISOR(ecd_pkg::MO_DIV)
	) u_mo (
		.clk(clk), .en_a(en[8]), .en_b(en[9]),
		.num(mo_num), .quo(mo_q), .rem(mo_r)
	);

	// Zeller counts January and February as months 13 and 14 of the prior year
	assign yz = (lane_s[10].month < ecd_pkg::MARCH) ? lane_s[10].year - 13'd1
	                                                 : lane_s[10].year;

	ecd_const_div #(
		.NUM_W(13), .QUO_W(6), .REM_W(7), .DIVISOR(ecd_pkg::CENT_DIV)
	) u_cent (
		.clk(clk), .en_a(en[11]), .en_b(en[12]),
		.num(yz), .quo(cent_q), .rem(yoc)
	);

	ecd_const_div #(
		.NUM_W(9), .QUO_W(6), .REM_W(3), .DIVISOR(ecd_pkg::WEEK_DIV)
	) u_wk (
		.clk(clk), .en_a(en[14]), .en_b(en[15]),
		.num(lane_s[13].sum), .quo(wk_q), .rem(wk_r)
	);

	assign t1 = {1'b0, t1_q} + ecd_pkg::T1_OFS;

	// ------------------------------------------------------------------
	// Lane payload: pass everything down, fill in fields where computed
	// ------------------------------------------------------------------
	always_comb begin
		lane_d[0]       = '0;
		lane_d[0].ts_lo = epoch_seconds[ecd_pkg::SEC_LO_W-1:0];
		for (int i = 1; i < NS; i++) begin
			lane_d[i] = lane_s[i-1];
		end

		lane_d[2].days = day_q;

		lane_d[4].hour = hr_q;
		lane_d[4].t2   = 22'(lane_s[3].days) + ecd_pkg::T2_BIAS + 22'(t1) - 22'(t1 >> 2);

		lane_d[6].minute = min_q;
		lane_d[6].second = min_r;

		// Day count from the March-based year start
		lane_d[7].yr = yr_q;
		lane_d[7].t3 = 9'(lane_s[6].t2 - 22'(yr_q) * ecd_pkg::DAYS_YEAR - 22'(yr_q >> 2));

		lane_d[10].dom = 5'(lane_s[9].t3 - 9'(mo_q) * ecd_pkg::DAYS_MO
		                    - 9'(ecd_pkg::month_frac(mo_q)));
		if (mo_q <= ecd_pkg::MO_SPLIT) begin
			lane_d[10].year  = 13'(lane_s[9].yr - ecd_pkg::YR_OFS_LO);
			lane_d[10].month = 4'(mo_q - 5'd1);
		end else begin
			lane_d[10].year  = 13'(lane_s[9].yr - ecd_pkg::YR_OFS_HI);
			lane_d[10].month = 4'(mo_q - ecd_pkg::MO_SPLIT);
		end

		lane_d[11].mz = (lane_s[10].month < ecd_pkg::MARCH)
		                ? lane_s[10].month + ecd_pkg::MO_YEAR : lane_s[10].month;

		// Bias keeps the sum positive before the two-century term comes off
		lane_d[13].sum = 9'(10'(cent_q >> 2) + 10'(yoc) + 10'(yoc >> 2)
		                    + 10'(ecd_pkg::zeller_month(lane_s[12].mz))
		                    + 10'(lane_s[12].dom) + ecd_pkg::ZEL_BIAS
		                    - 10'({cent_q, 1'b0}));
	end

	// ------------------------------------------------------------------
	// Output beat
	// ------------------------------------------------------------------
	assign date_valid   = vld_s[NS-1];
	assign year         = lane_s[NS-1].year[ecd_pkg::YEAR_W-1:0];
	assign month        = lane_s[NS-1].month;
	assign day_of_month = lane_s[NS-1].dom;
	assign weekday      = wk_r;
	assign hour         = lane_s[NS-1].hour;
	assign minute       = lane_s[NS-1].minute;
	assign second       = lane_s[NS-1].second;

endmodule

`default_nettype wire

>>> dv/tb_epoch_seconds_to_calendar_date_core.sv
// Testbench for epoch_seconds_to_calendar_date_core: directed and random timestamps,
// each checked against a behavioral calendar predictor. Depends on ecd_pkg and the RTL.
`default_nettype none

module tb_epoch_seconds_to_calendar_date_core;
	timeunit 1ns;
	timeprecision 1ps;

	// Last second of year 4095 and its day index; beyond it the year field wraps.
	localparam logic [ecd_pkg::EPOCH_W-1:0] LAST_SECOND = 36'd67090118399;
	localparam int unsigned LAST_DAY = 776505;
	localparam int unsigned SECS_PER_DAY = 86400;

	// One expected date beat, tagged with the timestamp that caused it.
	typedef struct {
		logic [ecd_pkg::EPOCH_W-1:0] epoch;
		logic [ecd_pkg::YEAR_W-1:0]  year;
		logic [ecd_pkg::MONTH_W-1:0] month;
		logic [ecd_pkg::DOM_W-1:0]   dom;
		logic [ecd_pkg::WDAY_W-1:0]  wday;
		logic [ecd_pkg::HOUR_W-1:0]  hour;
		logic [ecd_pkg::MIN_W-1:0]   minute;
		logic [ecd_pkg::SEC_W-1:0]   second;
	} date_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          epoch_valid = 1'b0;
	logic                          epoch_ready;
	logic [ecd_pkg::EPOCH_W-1:0]   epoch_seconds = '0;

	logic                          date_valid;
	logic                          date_ready = 1'b0;
	logic [ecd_pkg::YEAR_W-1:0]    year;
	logic [ecd_pkg::MONTH_W-1:0]   month;
	logic [ecd_pkg::DOM_W-1:0]     day_of_month;
	logic [ecd_pkg::WDAY_W-1:0]    weekday;
	logic [ecd_pkg::HOUR_W-1:0]    hour;
	logic [ecd_pkg::MIN_W-1:0]     minute;
	logic [ecd_pkg::SEC_W-1:0]     second;

	// Dates still owed by the block, oldest first.
	date_t pending_dates[$];
	int unsigned mismatches = 0;

	// Idle odds in percent for each side, and a long receiver hold counted
	// down by the receiver process itself.
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned sink_hold_cycles = 0;

	epoch_seconds_to_calendar_date_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.epoch_valid   (epoch_valid),
		.epoch_ready   (epoch_ready),
		.epoch_seconds (epoch_seconds),
		.date_valid    (date_valid),
		.date_ready    (date_ready),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month),
		.weekday       (weekday),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Calendar predictor. Time of day by plain division, the date by the
	// Julian-day integer method, the weekday by Zeller's congruence with a
	// bias of 7*20 so the century term never drives the sum negative.
	// Everything runs at 64 bits; only the output fields are truncated.
	function automatic date_t calendar_of(input logic [ecd_pkg::EPOCH_W-1:0] secs);
		longint unsigned ts, days, t1, t2, yr, t3, mo, dy;
		longint unsigned z_yr, z_mo, cent, yoc, zsum;
		date_t d;
		ts = secs;
		d.epoch  = secs;
		d.second = ecd_pkg::SEC_W'(ts % 60);
		ts       = ts / 60;
		d.minute = ecd_pkg::MIN_W'(ts % 60);
		ts       = ts / 60;
		d.hour   = ecd_pkg::HOUR_W'(ts % 24);
		days     = ts / 24;

		t1 = (4 * days + 102032) / 146097 + 15;
		t2 = days + 2442113 + t1 - t1 / 4;
		yr = (20 * t2 - 2442) / 7305;
		t3 = t2 - 365 * yr - yr / 4;
		mo = (t3 * 1000) / 30601;
		dy = t3 - mo * 30 - (mo * 601) / 1000;
		// Months count from March in the Julian-day form; fold back to Jan..Dec.
		if (mo <= 13) begin
			yr = yr - 4716;
			mo = mo - 1;
		end else begin
			yr = yr - 4715;
			mo = mo - 13;
		end

		// Zeller treats Jan and Feb as months 13 and 14 of the prior year.
		z_yr = yr;
		z_mo = mo;
		if (z_mo < 3) begin
			z_mo = z_mo + 12;
			z_yr = z_yr - 1;
		end
		cent = z_yr / 100;
		yoc  = z_yr % 100;
		zsum = cent / 4 + yoc + yoc / 4 + (13 * (z_mo + 1)) / 5 + dy - 1 + 140 - 2 * cent;

		d.year  = ecd_pkg::YEAR_W'(yr);
		d.month = ecd_pkg::MONTH_W'(mo);
		d.dom   = ecd_pkg::DOM_W'(dy);
		d.wday  = ecd_pkg::WDAY_W'(zsum % 7);
		return d;
	endfunction

	// Timestamp mix: mostly uniform over the legal range, a good share landing
	// on the first or last second of a day (month, year and leap edges), and
	// some over the full 36 bits, past year 4095 included.
	function automatic logic [ecd_pkg::EPOCH_W-1:0] pick_epoch();
		logic [ecd_pkg::EPOCH_W-1:0] v;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			do v = {4'($urandom_range(15, 0)), $urandom()};
			while (v > LAST_SECOND);
		end else if (sel < 88) begin
			v = 36'($urandom_range(LAST_DAY, 0)) * 36'(SECS_PER_DAY);
			if ($urandom_range(1))
				v = v + 36'(SECS_PER_DAY - 1);
		end else begin
			v = {4'($urandom_range(15, 0)), $urandom()};
		end
		return v;
	endfunction

	// Offer one timestamp beat, with random idle cycles ahead of it, and
	// record its date once the block takes it. Valid stays high across
	// back-to-back calls: only one assignment per clock edge.
	task automatic send_epoch(input logic [ecd_pkg::EPOCH_W-1:0] secs);
		while ($urandom_range(99) < src_idle_pct) begin
			epoch_valid   <= 1'b0;
			epoch_seconds <= {4'($urandom_range(15, 0)), $urandom()};
			@(posedge clk);
		end
		epoch_valid   <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (!epoch_ready)
			@(posedge clk);
		pending_dates.push_back(calendar_of(secs));
	endtask

	// Sender goes quiet until every owed date has come out.
	task automatic wait_drained();
		epoch_valid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [11:0] exp_v,
		input logic [11:0] act_v, input logic [ecd_pkg::EPOCH_W-1:0] secs);
		if (act_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s mismatch for epoch %0d: expected %0d, actual %0d",
				$time, name, secs, exp_v, act_v);
		end
	endtask

	// Receiver: random ready, or held low while a long hold is counting down.
	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				sink_hold_cycles--;
				date_ready <= 1'b0;
			end else begin
				date_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Result checker: every accepted date beat against the oldest expectation.
	initial begin
		date_t want;
		forever begin
			@(posedge clk);
			if (arst_n && date_valid === 1'b1 && date_ready === 1'b1) begin
				if (pending_dates.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected date beat: expected none, actual %0d-%0d-%0d %0d:%0d:%0d wd %0d",
						$time, year, month, day_of_month, hour, minute, second, weekday);
				end else begin
					want = pending_dates.pop_front();
					report_field("year", 12'(want.year), 12'(year), want.epoch);
					report_field("month", 12'(want.month), 12'(month), want.epoch);
					report_field("day_of_month", 12'(want.dom), 12'(day_of_month), want.epoch);
					report_field("weekday", 12'(want.wday), 12'(weekday), want.epoch);
					report_field("hour", 12'(want.hour), 12'(hour), want.epoch);
					report_field("minute", 12'(want.minute), 12'(minute), want.epoch);
					report_field("second", 12'(want.second), 12'(second), want.epoch);
				end
			end
		end
	end

	// Directed edges: the epoch itself, time-of-day rollovers, leap and
	// non-leap century Februaries, the 32-bit boundaries, the last second of
	// year 4095 and the wrap of the year field just past it, and bit patterns.
	task automatic test_directed();
		logic [ecd_pkg::EPOCH_W-1:0] edges[$];
		edges = '{36'd0, 36'd59, 36'd60, 36'd3599, 36'd86399, 36'd86400,
			36'd31535999, 36'd68169600, 36'd946684799, 36'd951782400,
			36'd951868799, 36'd2147483647, 36'd4102444799, 36'd4107542399,
			36'd4107542400, 36'hFFFF_FFFF, 36'h1_0000_0000,
			LAST_SECOND - 36'd86400, LAST_SECOND, LAST_SECOND + 36'd1,
			36'h5_5555_5555, 36'hA_AAAA_AAAA, 36'hF_FFFF_FFFF};
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		foreach (edges[i])
			send_epoch(edges[i]);
		wait_drained();
	endtask

	task automatic test_random(input int unsigned beats, input int unsigned src_pct,
		input int unsigned sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (beats)
			send_epoch(pick_epoch());
		wait_drained();
	endtask

	// Backpressure: receiver holds off far longer than the pipeline is deep
	// while the sender keeps offering, so every stage fills and epoch_ready
	// drops; afterwards the sender pauses until all dates are out.
	task automatic test_backpressure();
		src_idle_pct     = 0;
		sink_idle_pct    = 0;
		sink_hold_cycles = 150;
		repeat (40)
			send_epoch(pick_epoch());
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(510, 31, 72);
		test_backpressure();
		test_random(510, 72, 31);
		test_random(510, 0, 0);

		// Any stray beat would show up within the pipeline depth.
		repeat (ecd_pkg::STAGES + 8) @(posedge clk);
		if (mismatches == 0 && pending_dates.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog, well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hdl/ecd_pkg.sv
hdl/ecd_const_div.sv
hdl/epoch_seconds_to_calendar_date_core.sv
dv/tb_epoch_seconds_to_calendar_date_core.sv
